>>> rtl/core/bblf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblf_pkg
// Shared constants, types and the reciprocal table of the box blur line filter.
// ----------------------------------------------------------------------------
package bblf_pkg;

  localparam int MAX_RADIUS  = 15;
  localparam int RING_DEPTH  = 2 * MAX_RADIUS + 1;
  localparam int PIX_W       = 8;
  localparam int RAD_W       = 4;
  localparam int POS_W       = $clog2(RING_DEPTH);
  localparam int SEEN_W      = $clog2(RING_DEPTH + 1);
  localparam int REM_W       = RAD_W + 1;
  localparam int SUM_W       = 13;
  localparam int RECIP_SHIFT = 18;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam int PROD_W      = SUM_W + RECIP_W;

  localparam logic [RAD_W-1:0] RADIUS_RESET = RAD_W'(1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PUSH,
    S_MUL,
    S_EMIT
  } bblf_state_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic mul;
    logic load;
  } bblf_cmd_t;

  typedef struct packed {
    logic emit;
    logic more;
    logic out_free;
  } bblf_status_t;

  // ceil(2^18 / (2r+1)); exact floor division for numerators up to 13 bits
  function automatic logic [RECIP_W-1:0] recip(input logic [RAD_W-1:0] r);
    logic [RECIP_W-1:0] m;
    case (r)
      4'd0:    m = RECIP_W'(262144);
      4'd1:    m = RECIP_W'(87382);
      4'd2:    m = RECIP_W'(52429);
      4'd3:    m = RECIP_W'(37450);
      4'd4:    m = RECIP_W'(29128);
      4'd5:    m = RECIP_W'(23832);
      4'd6:    m = RECIP_W'(20165);
      4'd7:    m = RECIP_W'(17477);
      4'd8:    m = RECIP_W'(15421);
      4'd9:    m = RECIP_W'(13798);
      4'd10:   m = RECIP_W'(12484);
      4'd11:   m = RECIP_W'(11398);
      4'd12:   m = RECIP_W'(10486);
      4'd13:   m = RECIP_W'(9710);
      4'd14:   m = RECIP_W'(9040);
      4'd15:   m = RECIP_W'(8457);
      default: m = RECIP_W'(262144);
    endcase
    return m;
  endfunction

endpackage

>>> rtl/core/bblf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblf_ctrl
// Sequencer: accept a pixel, push it (and flush replicas), divide, emit.
// ----------------------------------------------------------------------------
module bblf_ctrl
  import bblf_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  bblf_status_t status,
  output bblf_cmd_t    cmd
);

  bblf_state_t state;
  bblf_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_PUSH;
      end
      S_PUSH: begin
        state_next = S_MUL;
      end
      S_MUL: begin
        if (status.emit) state_next = S_EMIT;
        else if (status.more) state_next = S_PUSH;
        else state_next = S_IDLE;
      end
      S_EMIT: begin
        if (status.out_free) state_next = status.more ? S_PUSH : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      S_IDLE: begin
        // no beat is taken while in reset
        in_ready   = !rst;
        cmd.accept = in_valid && !rst;
      end
      S_PUSH: begin
        cmd.push = 1'b1;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_EMIT: begin
        cmd.load = status.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

>>> rtl/core/bblf_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bblf_datapath
// Running sum, pixel ring, reciprocal divide and output register.
// ----------------------------------------------------------------------------
module bblf_datapath
  import bblf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic [RAD_W-1:0]   radius,
  input  logic [PIX_W-1:0]   pixel,
  input  logic               line_end,
  input  bblf_cmd_t          cmd,
  output bblf_status_t       status,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [PIX_W-1:0]   smoothed,
  output logic               last_of_line
);

  logic [RAD_W-1:0]  radius_cfg;
  logic [RAD_W-1:0]  line_radius;
  logic [PIX_W-1:0]  first_pixel;
  logic [PIX_W-1:0]  pixel_r;
  logic              end_r;
  logic [REM_W-1:0]  rem;
  logic [SUM_W-1:0]  running_sum;
  logic [SEEN_W-1:0] pixels_seen;
  logic [POS_W-1:0]  ring_pos;
  logic [PIX_W-1:0]  window_ring [RING_DEPTH];
  logic [SUM_W-1:0]  num_r;
  logic              emit_r;
  logic              last_r;
  logic [PIX_W-1:0]  quot_r;

  logic [POS_W-1:0]  win;
  logic [PIX_W-1:0]  leaving;
  logic [SUM_W-1:0]  sum_next;
  logic [POS_W:0]    pos_inc;
  logic              final_push;
  logic [RAD_W-1:0]  radius_eff;
  logic [PROD_W-1:0] product;

  assign win        = POS_W'({line_radius, 1'b1});
  assign leaving    = (pixels_seen >= SEEN_W'(win)) ? window_ring[ring_pos] : first_pixel;
  assign pos_inc    = {1'b0, ring_pos} + (POS_W+1)'(1);
  assign final_push = end_r && (rem == REM_W'(1));
  assign radius_eff = (pixels_seen == '0) ? radius_cfg : line_radius;
  assign product    = PROD_W'(num_r) * PROD_W'(recip(line_radius));

  always_comb begin
    if (pixels_seen == '0) begin
      sum_next = SUM_W'(win) * SUM_W'(pixel_r);
    end else begin
      sum_next = running_sum + SUM_W'(pixel_r) - SUM_W'(leaving);
    end
  end

  assign status.emit     = emit_r;
  assign status.more     = (rem != '0);
  assign status.out_free = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      radius_cfg  <= RADIUS_RESET;
      line_radius <= '0;
      first_pixel <= '0;
      running_sum <= '0;
      pixels_seen <= '0;
      ring_pos    <= '0;
      rem         <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) radius_cfg <= radius;
      if (cmd.accept) begin
        rem <= line_end ? REM_W'(radius_eff) + REM_W'(1) : REM_W'(1);
        if (pixels_seen == '0) begin
          line_radius <= radius_cfg;
          first_pixel <= pixel;
          ring_pos    <= '0;
        end
      end
      if (cmd.push) begin
        rem <= rem - REM_W'(1);
        if (final_push) begin
          running_sum <= '0;
          pixels_seen <= '0;
          ring_pos    <= '0;
        end else begin
          running_sum <= sum_next;
          ring_pos    <= (pos_inc >= (POS_W+1)'(win)) ? '0 : pos_inc[POS_W-1:0];
          if (pixels_seen < SEEN_W'(win)) pixels_seen <= pixels_seen + SEEN_W'(1);
        end
      end
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pixel_r <= pixel;
      end_r   <= line_end;
    end
    if (cmd.push) begin
      window_ring[ring_pos] <= pixel_r;
      num_r  <= sum_next + SUM_W'(line_radius);
      emit_r <= (pixels_seen >= SEEN_W'(line_radius));
      last_r <= final_push;
    end
    if (cmd.mul) begin
      quot_r <= product[RECIP_SHIFT +: PIX_W];
    end
    if (cmd.load) begin
      smoothed     <= quot_r;
      last_of_line <= last_r;
    end
  end

endmodule

>>> rtl/core/box_blur_line_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_line_filter
// Horizontal box blur of one image line with clamp-to-edge borders.
// ----------------------------------------------------------------------------
// each pixel position gets (window sum + r) / (2r+1) over the 2r+1 pixels
// around it, positions off either end take the first or last pixel. results
// lag the input by r pixels; the beat flagged line_end flushes the r+1 that
// are still due and the final one carries last_of_line, so every line gives
// one output beat per input beat. radius is sampled at the first pixel of
// each line, a write in mid-line applies from the next line. r = 0 passes
// pixels through. one pixel at a time: a pixel that gives no result goes
// through accept, sum update and reciprocal multiply, one that gives a
// result also through emit once the output is free, and each flush replica
// after a line end through sum update and multiply, then emit if it gives a
// result; these are the sequencer states. a finished beat waits in the
// output register while the next pixel is already taken in. cfg_ready and
// in_ready stay low while rst is high; out of reset cfg_ready is always high.
// ----------------------------------------------------------------------------
module box_blur_line_filter
  import bblf_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  // radius register write
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [RAD_W-1:0] radius,
  // pixel beats in
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [PIX_W-1:0] pixel,
  input  logic             line_end,
  // filtered beats out
  output logic             out_valid,
  input  logic             out_ready,
  output logic [PIX_W-1:0] smoothed,
  output logic             last_of_line
);

  bblf_cmd_t    cmd;
  bblf_status_t status;

  // the register is a plain flop, a write never stalls once out of reset
  assign cfg_ready = !rst;

  // sequencer: one step of accept, push, divide and emit per state
  bblf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // running sum, ring of recent pixels, reciprocal divide, output register
  bblf_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .radius       (radius),
    .pixel        (pixel),
    .line_end     (line_end),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .smoothed     (smoothed),
    .last_of_line (last_of_line)
  );

  // at most one sequencer command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.accept, cmd.push, cmd.mul, cmd.load}))
    else $error("more than one sequencer command in a cycle");

  // an accepted pixel is pushed into the window in the next cycle
  a_accept_push: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> cmd.push)
    else $error("accepted pixel not pushed");

  // a result is never loaded over a beat that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> (!out_valid || out_ready))
    else $error("output register overwritten");

  // every push is followed by its divide step
  a_push_mul: assert property (@(posedge clk) disable iff (rst)
    cmd.push |=> cmd.mul)
    else $error("push not followed by divide");

endmodule
